// File: design/sipnict_pkg.sv
// shared types, codes and helpers for the sip non-invite client transaction block
package sipnict_pkg;

  // timer counter width
  localparam int TICK_WIDTH = 16;
  localparam logic [32:0] TICK_MAX_W = (33'd1 << TICK_WIDTH) - 33'd1;

  // configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_W  = 16;

  // register indexes
  localparam logic [2:0] REG_BASE     = 3'd0;
  localparam logic [2:0] REG_CAP      = 3'd1;
  localparam logic [2:0] REG_GIVEUP   = 3'd2;
  localparam logic [2:0] REG_LINGER   = 3'd3;
  localparam logic [2:0] REG_RELIABLE = 3'd4;

  // register reset values
  localparam logic [REG_W-1:0] RST_BASE   = 16'd500;
  localparam logic [REG_W-1:0] RST_CAP    = 16'd4000;
  localparam logic [REG_W-1:0] RST_GIVEUP = 16'd32000;
  localparam logic [REG_W-1:0] RST_LINGER = 16'd5000;

  // transaction phases
  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_TRYING     = 2'd1;
  localparam logic [1:0] PH_PROCEEDING = 2'd2;
  localparam logic [1:0] PH_COMPLETED  = 2'd3;

  // input operations
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RESP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_TERR  = 2'd3;

  // result actions
  localparam logic [2:0] ACT_SEND    = 3'd0;
  localparam logic [2:0] ACT_PASS    = 3'd1;
  localparam logic [2:0] ACT_TIMEOUT = 3'd2;
  localparam logic [2:0] ACT_TERR    = 3'd3;
  localparam logic [2:0] ACT_DONE    = 3'd4;

  // status code classes
  localparam logic [9:0] CODE_MIN       = 10'd100;
  localparam logic [9:0] CODE_PROV_MAX  = 10'd199;
  localparam logic [9:0] CODE_FINAL_MAX = 10'd699;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    logic [REG_W-1:0] base;
    logic [REG_W-1:0] cap;
    logic [REG_W-1:0] giveup;
    logic [REG_W-1:0] linger;
    logic             reliable;
  } cfg_t;

  typedef struct packed {
    logic [2:0] action;
    logic [9:0] status;
    logic [1:0] phase;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  // timer load value: zero becomes one tick, oversize saturates
  function automatic logic [TICK_WIDTH-1:0] load_value(input logic [31:0] v);
    logic [TICK_WIDTH-1:0] r;
    if (v == 32'd0) begin
      r = TICK_WIDTH'(1);
    end else if ({1'b0, v} > TICK_MAX_W) begin
      r = '1;
    end else begin
      r = v[TICK_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/sipnict_cfg.sv
// configuration register file behind the apb-style port
module sipnict_cfg
  import sipnict_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base     <= RST_BASE;
      cfg_r.cap      <= RST_CAP;
      cfg_r.giveup   <= RST_GIVEUP;
      cfg_r.linger   <= RST_LINGER;
      cfg_r.reliable <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_BASE:     cfg_r.base     <= pwdata[REG_W-1:0];
        REG_CAP:      cfg_r.cap      <= pwdata[REG_W-1:0];
        REG_GIVEUP:   cfg_r.giveup   <= pwdata[REG_W-1:0];
        REG_LINGER:   cfg_r.linger   <= pwdata[REG_W-1:0];
        REG_RELIABLE: cfg_r.reliable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_BASE:     prdata = CFG_DW'(cfg_r.base);
      REG_CAP:      prdata = CFG_DW'(cfg_r.cap);
      REG_GIVEUP:   prdata = CFG_DW'(cfg_r.giveup);
      REG_LINGER:   prdata = CFG_DW'(cfg_r.linger);
      REG_RELIABLE: prdata = CFG_DW'(cfg_r.reliable);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: design/sipnict_core.sv
// input register, transaction state and timers, one item per cycle while the queue has room for two results
module sipnict_core
  import sipnict_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [9:0] in_status_code,
  input  cfg_t       cfg,
  input  logic       room2,
  output logic       push_en,
  output push_t      push
);

  logic                  in_valid_r;
  logic [1:0]            op_r;
  logic [9:0]            code_r;
  logic                  process;

  logic [1:0]            phase_r, phase_nxt;
  logic [TICK_WIDTH-1:0] ivl_r, ivl_nxt;
  logic [TICK_WIDTH-1:0] rsd_r, rsd_nxt;
  logic [TICK_WIDTH-1:0] gup_r, gup_nxt;
  logic [TICK_WIDTH-1:0] lng_r, lng_nxt;

  logic [1:0]            n;
  logic [2:0]            act0, act1;
  logic [9:0]            st0;
  logic [TICK_WIDTH-1:0] cap_v;
  logic [TICK_WIDTH-1:0] dbl_ivl;
  logic [31:0]           dbl;

  assign process  = in_valid_r && room2;
  assign in_ready = !in_valid_r || process;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      code_r <= in_status_code;
    end
  end

  // retransmit interval after timer e in trying
  assign cap_v   = load_value(32'(cfg.cap));
  assign dbl     = {32'(ivl_r)} << 1;
  assign dbl_ivl = (dbl < 32'(cap_v)) ? load_value(dbl) : cap_v;

  // next state and results
  always_comb begin
    phase_nxt = phase_r;
    ivl_nxt   = ivl_r;
    rsd_nxt   = rsd_r;
    gup_nxt   = gup_r;
    lng_nxt   = lng_r;
    n         = 2'd0;
    act0      = ACT_SEND;
    act1      = ACT_DONE;
    st0       = '0;
    case (op_r)
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_TRYING;
          gup_nxt   = load_value(32'(cfg.giveup));
          if (!cfg.reliable) begin
            ivl_nxt = load_value(32'(cfg.base));
            rsd_nxt = load_value(32'(cfg.base));
          end
          n    = 2'd1;
          act0 = ACT_SEND;
        end
      end
      OP_RESP: begin
        if ((phase_r inside {PH_TRYING, PH_PROCEEDING}) &&
            (code_r inside {[CODE_MIN:CODE_FINAL_MAX]})) begin
          n    = 2'd1;
          act0 = ACT_PASS;
          st0  = code_r;
          if (code_r <= CODE_PROV_MAX) begin
            phase_nxt = PH_PROCEEDING;
          end else if (cfg.reliable) begin
            phase_nxt = PH_IDLE;
            ivl_nxt   = '0;
            rsd_nxt   = '0;
            gup_nxt   = '0;
            lng_nxt   = '0;
            n         = 2'd2;
            act1      = ACT_DONE;
          end else begin
            phase_nxt = PH_COMPLETED;
            ivl_nxt   = '0;
            rsd_nxt   = '0;
            gup_nxt   = '0;
            lng_nxt   = load_value(32'(cfg.linger));
          end
        end
      end
      OP_TICK: begin
        if (phase_r inside {PH_TRYING, PH_PROCEEDING}) begin
          if (gup_r != '0) gup_nxt = gup_r - TICK_WIDTH'(1);
          if (rsd_r != '0) rsd_nxt = rsd_r - TICK_WIDTH'(1);
          if (gup_r == TICK_WIDTH'(1)) begin
            // timer f wins over timer e
            phase_nxt = PH_IDLE;
            ivl_nxt   = '0;
            rsd_nxt   = '0;
            gup_nxt   = '0;
            lng_nxt   = '0;
            n         = 2'd1;
            act0      = ACT_TIMEOUT;
          end else if (rsd_r == TICK_WIDTH'(1)) begin
            if (phase_r == PH_TRYING) begin
              ivl_nxt = dbl_ivl;
              rsd_nxt = dbl_ivl;
            end else begin
              ivl_nxt = cap_v;
              rsd_nxt = cap_v;
            end
            n    = 2'd1;
            act0 = ACT_SEND;
          end
        end else if (phase_r == PH_COMPLETED) begin
          // timer k expires, or was never armed
          if (lng_r <= TICK_WIDTH'(1)) begin
            phase_nxt = PH_IDLE;
            ivl_nxt   = '0;
            rsd_nxt   = '0;
            gup_nxt   = '0;
            lng_nxt   = '0;
            n         = 2'd1;
            act0      = ACT_DONE;
          end else begin
            lng_nxt = lng_r - TICK_WIDTH'(1);
          end
        end
      end
      default: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt = PH_IDLE;
          ivl_nxt   = '0;
          rsd_nxt   = '0;
          gup_nxt   = '0;
          lng_nxt   = '0;
          n         = 2'd1;
          act0      = ACT_TERR;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ivl_r   <= '0;
      rsd_r   <= '0;
      gup_r   <= '0;
      lng_r   <= '0;
    end else if (process) begin
      phase_r <= phase_nxt;
      ivl_r   <= ivl_nxt;
      rsd_r   <= rsd_nxt;
      gup_r   <= gup_nxt;
      lng_r   <= lng_nxt;
    end
  end

  // results to the queue
  assign push_en          = process && (n != 2'd0);
  assign push.count       = n;
  assign push.res0.action = act0;
  assign push.res0.status = st0;
  assign push.res0.phase  = phase_nxt;
  assign push.res0.last   = (n == 2'd1);
  assign push.res1.action = act1;
  assign push.res1.status = '0;
  assign push.res1.phase  = phase_nxt;
  assign push.res1.last   = 1'b1;

endmodule

// File: design/sipnict_outq.sv
// result queue, takes one or two items a cycle and hands out one
module sipnict_outq
  import sipnict_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_en,
  input  push_t push,
  output logic  room2,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [OQ_CW-1:0] cnt_after_pop;
  logic [OQ_AW-1:0] wr_ptr1;

  assign out_valid     = (cnt_r != '0);
  assign out_res       = mem[rd_ptr_r];
  assign pop           = out_valid && out_ready;
  assign cnt_after_pop = cnt_r - OQ_CW'(pop);
  assign room2         = (cnt_after_pop <= OQ_CW'(OQ_DEPTH - 2));
  assign wr_ptr1       = wr_ptr_r + OQ_AW'(1);
  assign cnt_nxt       = cnt_after_pop + (push_en ? OQ_CW'(push.count) : '0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_ptr_r] <= push.res0;
      if (push.count == 2'd2) begin
        mem[wr_ptr1] <= push.res1;
      end
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_r <= wr_ptr_r + OQ_AW'(push.count);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: design/sip_non_invite_client_transaction_top.sv
// top level of the sip non-invite client transaction block
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_operation, in_status_code
//   out_     output     out_valid / out_ready out_action, out_passed_status,
//                                             out_phase_after, out_last
//   cfg      input      psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// an item is taken into the input register, then updates the state and
// writes its one or two results into a four-entry result queue: one item
// per cycle while the queue keeps room for two results.
// reset clears the state, timers, queue and registers to their defaults.
// a stalled output holds items in the queue and backs up the input.
module sip_non_invite_client_transaction_top
  import sipnict_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [9:0]        in_status_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_action,
  output logic [9:0]        out_passed_status,
  output logic [1:0]        out_phase_after,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  logic  room2;
  logic  push_en;
  push_t push;
  res_t  out_res;

  sipnict_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sipnict_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_status_code (in_status_code),
    .cfg            (cfg),
    .room2          (room2),
    .push_en        (push_en),
    .push           (push)
  );

  sipnict_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (push_en),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // result fields
  assign out_action        = out_res.action;
  assign out_passed_status = out_res.status;
  assign out_phase_after   = out_res.phase;
  assign out_last          = out_res.last;

endmodule

// File: verif/nict_result_checker.sv
`timescale 1ns / 1ps
// result checker for the sip non-invite client transaction block: tracks state and compares items
module nict_result_checker
  import sipnict_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [9:0]        in_status_code,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_action,
  input  logic [9:0]        out_passed_status,
  input  logic [1:0]        out_phase_after,
  input  logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                handled_items
);

  localparam int LW = TICK_WIDTH + 1;

  typedef logic [TICK_WIDTH-1:0] ticks_t;

  // shadow copies of the timer registers
  logic [REG_W-1:0] t1_ticks;
  logic [REG_W-1:0] t2_ticks;
  logic [REG_W-1:0] f_ticks;
  logic [REG_W-1:0] k_ticks;
  logic             reliable;

  // transaction phase and timers
  logic [1:0] txn_phase;
  ticks_t     e_interval;
  ticks_t     e_count;
  ticks_t     f_count;
  ticks_t     k_count;

  res_t predicted_actions[$];
  int   fails;
  int   handled;

  // timer load: zero means one tick, oversize saturates
  function automatic ticks_t timer_load(input logic [LW-1:0] v);
    if (v == '0) return ticks_t'(1);
    if (v > {1'b0, {TICK_WIDTH{1'b1}}}) return '1;
    return v[TICK_WIDTH-1:0];
  endfunction

  // back to idle with every timer disarmed
  task automatic end_transaction();
    txn_phase  = PH_IDLE;
    e_interval = '0;
    e_count    = '0;
    f_count    = '0;
    k_count    = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] result check: %s", $time, msg);
    fails++;
  endtask

  // advance the transaction by one input item and queue its results
  task automatic step_transaction(input logic [1:0] op, input logic [9:0] code);
    logic [2:0]    acts [2];
    logic [9:0]    codes [2];
    logic          f_fire;
    logic          e_fire;
    logic [LW-1:0] doubled;
    ticks_t        cap;
    res_t          r;
    int            n;
    int            i;
    n = 0;
    case (op)
      OP_START: begin
        if (txn_phase == PH_IDLE) begin
          txn_phase = PH_TRYING;
          f_count = timer_load(LW'(f_ticks));
          if (!reliable) begin
            e_interval = timer_load(LW'(t1_ticks));
            e_count = e_interval;
          end
          acts[n] = ACT_SEND;
          codes[n] = '0;
          n++;
        end
      end
      OP_RESP: begin
        if ((txn_phase == PH_TRYING || txn_phase == PH_PROCEEDING) &&
            code >= CODE_MIN && code <= CODE_FINAL_MAX) begin
          acts[n] = ACT_PASS;
          codes[n] = code;
          n++;
          if (code <= CODE_PROV_MAX) begin
            txn_phase = PH_PROCEEDING;
          end else if (reliable) begin
            end_transaction();
            acts[n] = ACT_DONE;
            codes[n] = '0;
            n++;
          end else begin
            txn_phase = PH_COMPLETED;
            e_count = '0;
            f_count = '0;
            e_interval = '0;
            k_count = timer_load(LW'(k_ticks));
          end
        end
      end
      OP_TICK: begin
        if (txn_phase == PH_TRYING || txn_phase == PH_PROCEEDING) begin
          // both timers count; F takes precedence over E
          f_fire = (f_count == ticks_t'(1));
          e_fire = (e_count == ticks_t'(1));
          if (f_count != '0) f_count--;
          if (e_count != '0) e_count--;
          if (f_fire) begin
            end_transaction();
            acts[n] = ACT_TIMEOUT;
            codes[n] = '0;
            n++;
          end else if (e_fire) begin
            cap = timer_load(LW'(t2_ticks));
            if (txn_phase == PH_TRYING) begin
              doubled = {e_interval, 1'b0};
              e_interval = (doubled < LW'(cap)) ? timer_load(doubled) : cap;
            end else begin
              e_interval = cap;
            end
            e_count = e_interval;
            acts[n] = ACT_SEND;
            codes[n] = '0;
            n++;
          end
        end else if (txn_phase == PH_COMPLETED) begin
          if (k_count != '0) k_count--;
          if (k_count == '0) begin
            end_transaction();
            acts[n] = ACT_DONE;
            codes[n] = '0;
            n++;
          end
        end
      end
      default: begin
        if (txn_phase != PH_IDLE) begin
          end_transaction();
          acts[n] = ACT_TERR;
          codes[n] = '0;
          n++;
        end
      end
    endcase
    // every accepted item counts toward the run length
    handled++;
    for (i = 0; i < n; i++) begin
      r.action = acts[i];
      r.status = codes[i];
      r.phase  = txn_phase;
      r.last   = (i == n - 1);
      predicted_actions.push_back(r);
    end
  endtask

  // compare one result item against the oldest prediction
  task automatic check_result();
    res_t want;
    if (predicted_actions.size() == 0) begin
      report_mismatch($sformatf("unexpected item, action %0d status %0d",
                                out_action, out_passed_status));
    end else begin
      want = predicted_actions.pop_front();
      if (out_action !== want.action)
        report_mismatch($sformatf("action %0d, expected %0d", out_action, want.action));
      if (out_passed_status !== want.status)
        report_mismatch($sformatf("passed_status %0d, expected %0d",
                                  out_passed_status, want.status));
      if (out_phase_after !== want.phase)
        report_mismatch($sformatf("phase_after %0d, expected %0d",
                                  out_phase_after, want.phase));
      if (out_last !== want.last)
        report_mismatch($sformatf("last %0d, expected %0d", out_last, want.last));
    end
  endtask

  // watch the register port and both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      t1_ticks = RST_BASE;
      t2_ticks = RST_CAP;
      f_ticks  = RST_GIVEUP;
      k_ticks  = RST_LINGER;
      reliable = 1'b0;
      end_transaction();
      predicted_actions.delete();
      fails = 0;
      handled = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_AW-1:2])
          REG_BASE:     t1_ticks = pwdata[REG_W-1:0];
          REG_CAP:      t2_ticks = pwdata[REG_W-1:0];
          REG_GIVEUP:   f_ticks  = pwdata[REG_W-1:0];
          REG_LINGER:   k_ticks  = pwdata[REG_W-1:0];
          REG_RELIABLE: reliable = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) step_transaction(in_operation, in_status_code);
    end
    fail_count    <= fails;
    pending       <= predicted_actions.size();
    handled_items <= handled;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// testbench top: stimulus, idling and verdict for the sip non-invite client transaction block
module tb;
  import sipnict_pkg::*;

  localparam int STALL_LIMIT       = 2000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int ITEMS_PER_SETTING = 75;
  localparam int NUM_SETTINGS      = 6;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_operation = OP_START;
  logic [9:0]        in_status_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_action;
  logic [9:0]        out_passed_status;
  logic [1:0]        out_phase_after;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int handled_items;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cur_giveup = RST_GIVEUP;
  int cur_linger = RST_LINGER;
  int idle_cycles;

  sip_non_invite_client_transaction_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_status_code    (in_status_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_passed_status (out_passed_status),
    .out_phase_after   (out_phase_after),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  nict_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_status_code    (in_status_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_passed_status (out_passed_status),
    .out_phase_after   (out_phase_after),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .fail_count        (fail_count),
    .pending           (pending),
    .handled_items     (handled_items)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog on cycles with no handshake anywhere
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [9:0] any_code();
    return 10'($urandom_range(999));
  endfunction

  function automatic int tick_reach(input int span);
    return (span < 30) ? span + 2 : 30;
  endfunction

  // one input item, with a random gap ahead of it
  task automatic send_item(input logic [1:0] op, input logic [9:0] code);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_status_code <= code;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, any_code());
  endtask

  // hold the input until every predicted result has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access phase; select stays up between back-to-back writes
  task automatic cfg_write(input logic [2:0] idx, input logic [REG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_timers(input logic [REG_W-1:0] t1, input logic [REG_W-1:0] t2,
                                input logic [REG_W-1:0] f, input logic [REG_W-1:0] k,
                                input logic rel);
    wait_drained();
    cfg_write(REG_BASE, t1);
    cfg_write(REG_CAP, t2);
    cfg_write(REG_GIVEUP, f);
    cfg_write(REG_LINGER, k);
    cfg_write(REG_RELIABLE, REG_W'(rel));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_giveup = f;
    cur_linger = k;
  endtask

  task automatic apply_setting(input int s);
    case (s)
      0: program_timers(16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
      1: program_timers(16'd3, 16'd12, 16'd40, 16'd6, 1'b0);
      2: program_timers(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
      3: program_timers(16'($urandom_range(1, 8)), 16'($urandom_range(1, 32)),
                        16'($urandom_range(1, 60)), 16'($urandom_range(1, 10)), 1'b0);
      4: program_timers(16'd2, 16'd8, 16'd30, 16'd3, 1'b1);
      default: program_timers(16'($urandom_range(1, 8)), 16'($urandom_range(1, 32)),
                              16'($urandom_range(1, 60)), 16'($urandom_range(1, 10)),
                              1'($urandom_range(1)));
    endcase
  endtask

  // a full transaction with random timing and outcome
  task automatic run_transaction();
    int pick;
    send_item(OP_START, any_code());
    repeat ($urandom_range(tick_reach(cur_giveup))) send_tick();
    if ($urandom_range(1) == 1) begin
      send_item(OP_RESP, 10'($urandom_range(199, 100)));
      repeat ($urandom_range(tick_reach(cur_giveup))) send_tick();
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_item(OP_RESP, 10'($urandom_range(699, 200)));
    end else if (pick < 85) begin
      send_item(OP_TERR, any_code());
    end
    // retransmitted response while completed
    if ($urandom_range(3) == 0) send_item(OP_RESP, 10'($urandom_range(699, 100)));
    repeat ($urandom_range(tick_reach(cur_linger))) send_tick();
    if ($urandom_range(4) == 0) send_item(OP_TERR, any_code());
  endtask

  initial begin
    int s;
    int base_count;
    int txn_count;
    tx_idle_pct = 33;
    rx_idle_pct = 57;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored while idle: tick, response, transport error
    send_tick();
    send_item(OP_RESP, 10'd200);
    send_item(OP_TERR, any_code());
    // start, then a second start and out-of-range codes are ignored
    send_item(OP_START, any_code());
    send_item(OP_START, 10'd999);
    send_item(OP_RESP, 10'd0);
    send_item(OP_RESP, 10'd700);
    send_item(OP_RESP, 10'd999);
    // provisional class at both ends, then a final response
    send_item(OP_RESP, 10'd100);
    send_item(OP_RESP, 10'd199);
    send_item(OP_RESP, 10'd200);
    // response absorbed in completed, transport error still reported
    send_item(OP_RESP, 10'd699);
    send_item(OP_TERR, any_code());
    // retransmit doubling up to the cap, then E and F on the same tick
    program_timers(16'd1, 16'd2, 16'd5, 16'd1, 1'b0);
    send_item(OP_START, any_code());
    repeat (5) send_tick();
    // retransmit in proceeding reloads the cap, one-tick linger ends it
    send_item(OP_START, any_code());
    send_item(OP_RESP, 10'd100);
    send_tick();
    send_item(OP_RESP, 10'd486);
    send_tick();
    // reliable transport finishes on the final response
    program_timers(16'd1, 16'd2, 16'd5, 16'd1, 1'b1);
    send_item(OP_START, any_code());
    send_item(OP_RESP, 10'd404);
    // zero registers load as one tick
    program_timers(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_item(OP_START, any_code());
    send_tick();

    // random transactions under each register setting
    for (s = 0; s < NUM_SETTINGS; s++) begin
      case (s / 2)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      apply_setting(s);
      base_count = handled_items;
      txn_count = 0;
      while (handled_items - base_count < ITEMS_PER_SETTING) begin
        if ($urandom_range(99) < 80) begin
          run_transaction();
        end else begin
          repeat ($urandom_range(1, 3)) send_item(2'($urandom_range(3)), any_code());
        end
        txn_count++;
        // let the result side run dry now and then
        if (txn_count % 15 == 7) wait_drained();
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sip_non_invite_client_transaction_top.f
design/sipnict_pkg.sv
design/sipnict_cfg.sv
design/sipnict_core.sv
design/sipnict_outq.sv
design/sip_non_invite_client_transaction_top.sv
verif/nict_result_checker.sv
verif/tb.sv
